// ===== hw/rtl/sav_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sav_pkg
// shared widths, constants and types of the sutherland viscosity pipeline
// ----------------------------------------------------------------------------
package sav_pkg;

    localparam int TEMP_W    = 15;                 // celsius input, signed q.4
    localparam int KT_W      = 15;                 // absolute temperature, t0, c
    localparam int DSUM_W    = 16;                 // t + c
    localparam int FRAC_W    = 32;                 // fraction bits of ratio, root, power
    localparam int NUM_W     = KT_W + FRAC_W;      // ratio dividend
    localparam int RATIO_W   = 48;                 // ratio t / t0, q.32
    localparam int ROOT_W    = 40;                 // square root of ratio, q.32
    localparam int SQ_REM_W  = ROOT_W + 2;         // root remainder
    localparam int POW_W     = 56;                 // ratio^1.5, q.32
    localparam int VISC_W    = 20;
    localparam int SCALE_W   = VISC_W + DSUM_W;    // mu0 * (t0 + c)
    localparam int WQ_W      = SCALE_W + POW_W + 1 - FRAC_W;
    localparam int QREM_W    = DSUM_W + VISC_W;
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 2;

    localparam logic signed [KT_W:0] KELVIN_OFFSET = 16'sd4370;
    localparam logic [VISC_W-1:0]    VISC_MAX      = '1;

    localparam logic [VISC_W-1:0] REF_VISC_RESET   = 20'd182700;
    localparam logic [KT_W-1:0]   REF_TEMP_RESET   = 15'd4658;
    localparam logic [KT_W-1:0]   SUTH_CONST_RESET = 15'd1920;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REF_VISC   = 2'd0,
        REG_REF_TEMP   = 2'd1,
        REG_SUTH_CONST = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic              zero;
        logic [DSUM_W-1:0] dsum;
    } side_t;

endpackage

// ===== hw/rtl/sav_ratio_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sav_ratio_div
// pipelined restoring divider, one quotient bit per stage: round(t * 2^32 / t0)
// ----------------------------------------------------------------------------
module sav_ratio_div
    import sav_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [KT_W-1:0]    in_t,
    input  side_t              in_side,
    input  logic [KT_W-1:0]    t0,
    output logic               out_valid,
    output logic [RATIO_W-1:0] out_ratio,
    output side_t              out_side
);

    logic              v_reg    [0:NUM_W];
    logic [NUM_W-1:0]  nq_reg   [0:NUM_W];
    logic [KT_W-1:0]   rem_reg  [0:NUM_W];
    side_t             side_reg [0:NUM_W];
    logic [NUM_W-1:0]  nq_next  [1:NUM_W];
    logic [KT_W-1:0]   rem_next [1:NUM_W];
    logic [NUM_W-1:0]  num;

    // dividend with half the divisor added for round to nearest
    assign num = {in_t, {FRAC_W{1'b0}}} + {{(NUM_W-KT_W+1){1'b0}}, t0[KT_W-1:1]};

    always_comb
    begin
        logic [KT_W:0] cur;
        logic [KT_W:0] diff;
        logic          ge;
        for (int k = 0; k < NUM_W; k++)
        begin
            cur  = {rem_reg[k], nq_reg[k][NUM_W-1]};
            diff = cur - {1'b0, t0};
            ge   = (cur >= {1'b0, t0});
            rem_next[k+1] = ge ? diff[KT_W-1:0] : cur[KT_W-1:0];
            nq_next[k+1]  = {nq_reg[k][NUM_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NUM_W; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int k = 0; k < NUM_W; k++)
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nq_reg[0]   <= num;
            rem_reg[0]  <= '0;
            side_reg[0] <= in_side;
            for (int k = 0; k < NUM_W; k++)
            begin
                nq_reg[k+1]   <= nq_next[k+1];
                rem_reg[k+1]  <= rem_next[k+1];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = v_reg[NUM_W];
    assign out_ratio = {{(RATIO_W-NUM_W){1'b0}}, nq_reg[NUM_W]};
    assign out_side  = side_reg[NUM_W];

endmodule

// ===== hw/rtl/sav_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sav_sqrt
// pipelined digit-by-digit square root of ratio * 2^32, rounded to nearest
// ----------------------------------------------------------------------------
module sav_sqrt
    import sav_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [RATIO_W-1:0] in_ratio,
    input  side_t              in_side,
    output logic               out_valid,
    output logic [RATIO_W-1:0] out_ratio,
    output logic [ROOT_W-1:0]  out_root,
    output side_t              out_side
);

    logic                v_reg    [0:ROOT_W];
    logic [ROOT_W-1:0]   root_reg [0:ROOT_W];
    logic [SQ_REM_W-1:0] rem_reg  [0:ROOT_W];
    logic [RATIO_W-1:0]  r_reg    [0:ROOT_W];
    side_t               side_reg [0:ROOT_W];
    logic [ROOT_W-1:0]   root_next [1:ROOT_W];
    logic [SQ_REM_W-1:0] rem_next  [1:ROOT_W];

    logic                fin_v_reg;
    logic [ROOT_W-1:0]   fin_root_reg;
    logic [RATIO_W-1:0]  fin_r_reg;
    side_t               fin_side_reg;

    always_comb
    begin
        logic [SQ_REM_W+1:0] cur;
        logic [SQ_REM_W+1:0] trial;
        logic [SQ_REM_W+1:0] diff;
        logic [1:0]          pair;
        logic                ge;
        int                  i;
        for (int k = 0; k < ROOT_W; k++)
        begin
            i = ROOT_W - 1 - k;
            // radicand is ratio shifted up by 32, its low pairs are zero
            if (2 * i >= FRAC_W)
            begin
                pair = r_reg[k][2*i-FRAC_W +: 2];
            end
            else
            begin
                pair = 2'b00;
            end
            cur   = {rem_reg[k], pair};
            trial = {{(SQ_REM_W-ROOT_W){1'b0}}, root_reg[k], 2'b01};
            diff  = cur - trial;
            ge    = (cur >= trial);
            rem_next[k+1]  = ge ? diff[SQ_REM_W-1:0] : cur[SQ_REM_W-1:0];
            root_next[k+1] = {root_reg[k][ROOT_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= ROOT_W; k++)
            begin
                v_reg[k] <= 1'b0;
            end
            fin_v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int k = 0; k < ROOT_W; k++)
            begin
                v_reg[k+1] <= v_reg[k];
            end
            fin_v_reg <= v_reg[ROOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            root_reg[0] <= '0;
            rem_reg[0]  <= '0;
            r_reg[0]    <= in_ratio;
            side_reg[0] <= in_side;
            for (int k = 0; k < ROOT_W; k++)
            begin
                root_reg[k+1] <= root_next[k+1];
                rem_reg[k+1]  <= rem_next[k+1];
                r_reg[k+1]    <= r_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
            // round up when the remainder exceeds the root
            fin_root_reg <= root_reg[ROOT_W]
                + {{(ROOT_W-1){1'b0}},
                   (rem_reg[ROOT_W] > {{(SQ_REM_W-ROOT_W){1'b0}}, root_reg[ROOT_W]})};
            fin_r_reg    <= r_reg[ROOT_W];
            fin_side_reg <= side_reg[ROOT_W];
        end
    end

    assign out_valid = fin_v_reg;
    assign out_ratio = fin_r_reg;
    assign out_root  = fin_root_reg;
    assign out_side  = fin_side_reg;

endmodule

// ===== hw/rtl/sav_mult.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sav_mult
// power = round(ratio * root / 2^32), then mu0 * (t0 + c) * power with the
// half-divisor rounding term, split into registered partial products
// ----------------------------------------------------------------------------
module sav_mult
    import sav_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [RATIO_W-1:0] in_ratio,
    input  logic [ROOT_W-1:0]  in_root,
    input  side_t              in_side,
    input  logic [SCALE_W-1:0] scale,
    output logic               out_valid,
    output logic [WQ_W-1:0]    out_w,
    output side_t              out_side
);

    localparam int RS_W    = ROOT_W / 2;
    localparam int PP_W    = RATIO_W + RS_W;
    localparam int SUM_W   = RATIO_W + ROOT_W;
    localparam int PS_W    = POW_W / 2;
    localparam int QP_W    = SCALE_W + PS_W;
    localparam int SUM2_W  = SCALE_W + POW_W + 1;

    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    side_t              side1_reg, side2_reg, side3_reg, side4_reg;
    logic [PP_W-1:0]    pp0_reg, pp1_reg;
    logic [POW_W-1:0]   pow_reg;
    logic [QP_W-1:0]    qp0_reg, qp1_reg;
    logic [WQ_W-1:0]    w_reg;
    logic [SUM_W-1:0]   sum_next;
    logic [SUM2_W-1:0]  sum2_next;

    assign sum_next = {{(SUM_W-PP_W){1'b0}}, pp0_reg}
                    + {pp1_reg, {RS_W{1'b0}}}
                    + {{(SUM_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};

    assign sum2_next = {{(SUM2_W-QP_W){1'b0}}, qp0_reg}
                     + {{(SUM2_W-QP_W-PS_W){1'b0}}, qp1_reg, {PS_W{1'b0}}}
                     + {{(SUM2_W-DSUM_W-FRAC_W+1){1'b0}}, side3_reg.dsum,
                        {(FRAC_W-1){1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp0_reg   <= {{RS_W{1'b0}}, in_ratio} * {{RATIO_W{1'b0}}, in_root[RS_W-1:0]};
            pp1_reg   <= {{RS_W{1'b0}}, in_ratio}
                       * {{RATIO_W{1'b0}}, in_root[ROOT_W-1:RS_W]};
            side1_reg <= in_side;
            pow_reg   <= sum_next[SUM_W-1:FRAC_W];
            side2_reg <= side1_reg;
            qp0_reg   <= {{PS_W{1'b0}}, scale} * {{SCALE_W{1'b0}}, pow_reg[PS_W-1:0]};
            qp1_reg   <= {{PS_W{1'b0}}, scale} * {{SCALE_W{1'b0}}, pow_reg[POW_W-1:PS_W]};
            side3_reg <= side2_reg;
            w_reg     <= sum2_next[SUM2_W-1:FRAC_W];
            side4_reg <= side3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_w     = w_reg;
    assign out_side  = side4_reg;

endmodule

// ===== hw/rtl/sav_quot.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sav_quot
// final quotient w / (t + c) with saturation check, one bit per stage
// ----------------------------------------------------------------------------
module sav_quot
    import sav_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [WQ_W-1:0]   in_w,
    input  side_t             in_side,
    output logic              out_valid,
    output logic [VISC_W-1:0] out_q,
    output logic              out_sat,
    output side_t             out_side
);

    logic              v_reg    [0:VISC_W];
    logic [QREM_W-1:0] rem_reg  [0:VISC_W];
    logic [VISC_W-1:0] q_reg    [0:VISC_W];
    logic              sat_reg  [0:VISC_W];
    side_t             side_reg [0:VISC_W];
    logic [QREM_W-1:0] rem_next [1:VISC_W];
    logic [VISC_W-1:0] q_next   [1:VISC_W];
    logic              sat_in;

    // quotient would not fit the field
    assign sat_in = (in_w >= {{(WQ_W-QREM_W){1'b0}}, in_side.dsum, {VISC_W{1'b0}}});

    always_comb
    begin
        logic [QREM_W-1:0] dsh;
        logic              ge;
        for (int k = 0; k < VISC_W; k++)
        begin
            dsh = {{VISC_W{1'b0}}, side_reg[k].dsum} << (VISC_W - 1 - k);
            ge  = (rem_reg[k] >= dsh);
            rem_next[k+1] = ge ? (rem_reg[k] - dsh) : rem_reg[k];
            q_next[k+1]   = {q_reg[k][VISC_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= VISC_W; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int k = 0; k < VISC_W; k++)
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= in_w[QREM_W-1:0];
            q_reg[0]    <= '0;
            sat_reg[0]  <= sat_in;
            side_reg[0] <= in_side;
            for (int k = 0; k < VISC_W; k++)
            begin
                rem_reg[k+1]  <= rem_next[k+1];
                q_reg[k+1]    <= q_next[k+1];
                sat_reg[k+1]  <= sat_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = v_reg[VISC_W];
    assign out_q     = q_reg[VISC_W];
    assign out_sat   = sat_reg[VISC_W];
    assign out_side  = side_reg[VISC_W];

endmodule

// ===== hw/rtl/sutherland_air_viscosity.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sutherland_air_viscosity
// dynamic viscosity of a gas from its temperature by sutherland's law
// ----------------------------------------------------------------------------
// Takes one celsius temperature (signed, 4 fraction bits) per beat and returns
// mu0 * (t0 + c) / (t + c) * (t / t0)^1.5 in units of 1e-10 Pa*s, saturated at
// the 20-bit maximum with a flag. One beat is accepted every cycle unless the
// output stalls. It holds the bit-per-stage ratio divider (48 stages), the
// square root pipeline (42 stages) and the final quotient (21 stages).
// Temperatures at or below absolute zero give zero. A reference temperature
// of zero acts as one sixteenth kelvin. Write the constants only while no
// beat is in flight; a stall on the output side holds the whole pipeline.
// ----------------------------------------------------------------------------
module sutherland_air_viscosity
    import sav_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,    // temp_c[14:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,    // viscosity[19:0], saturated[20]
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [VISC_W-1:0]  ref_visc_reg;
    logic [KT_W-1:0]    ref_temp_reg;
    logic [KT_W-1:0]    suth_const_reg;
    logic [KT_W-1:0]    t0_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [KT_W-1:0]    t0_next;

    logic               en;
    logic               in_v_reg;
    logic [KT_W-1:0]    in_t_reg;
    side_t              in_side_reg;
    logic signed [KT_W:0] tk;
    side_t              side_next;

    logic               div_v;
    logic [RATIO_W-1:0] div_r;
    side_t              div_side;
    logic               sq_v;
    logic [RATIO_W-1:0] sq_r;
    logic [ROOT_W-1:0]  sq_s;
    side_t              sq_side;
    logic               mul_v;
    logic [WQ_W-1:0]    mul_w;
    side_t              mul_side;
    logic               quo_v;
    logic [VISC_W-1:0]  quo_q;
    logic               quo_sat;
    side_t              quo_side;

    logic               out_v_reg;
    logic [VISC_W-1:0]  visc_reg;
    logic               sat_reg;

    assign en       = !out_v_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_visc_reg   <= REF_VISC_RESET;
            ref_temp_reg   <= REF_TEMP_RESET;
            suth_const_reg <= SUTH_CONST_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_REF_VISC:   ref_visc_reg   <= cfg_data[VISC_W-1:0];
                REG_REF_TEMP:   ref_temp_reg   <= cfg_data[KT_W-1:0];
                REG_SUTH_CONST: suth_const_reg <= cfg_data[KT_W-1:0];
                default:        ;
            endcase
        end
    end

    // constants derived from the registers
    assign t0_next = (ref_temp_reg == '0) ? {{(KT_W-1){1'b0}}, 1'b1} : ref_temp_reg;

    always_ff @(posedge clk)
    begin
        t0_reg    <= t0_next;
        scale_reg <= {{DSUM_W{1'b0}}, ref_visc_reg}
                   * {{VISC_W{1'b0}}, ({1'b0, t0_next} + {1'b0, suth_const_reg})};
    end

    // celsius to kelvin
    assign tk = $signed({s_tdata[TEMP_W-1], s_tdata[TEMP_W-1:0]}) + KELVIN_OFFSET;
    assign side_next.zero = tk[KT_W] || (tk == '0);
    assign side_next.dsum = {1'b0, tk[KT_W-1:0]} + {1'b0, suth_const_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else if (en)
        begin
            in_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_t_reg    <= tk[KT_W-1:0];
            in_side_reg <= side_next;
        end
    end

    sav_ratio_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_v_reg),
        .in_t      (in_t_reg),
        .in_side   (in_side_reg),
        .t0        (t0_reg),
        .out_valid (div_v),
        .out_ratio (div_r),
        .out_side  (div_side)
    );

    sav_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_v),
        .in_ratio  (div_r),
        .in_side   (div_side),
        .out_valid (sq_v),
        .out_ratio (sq_r),
        .out_root  (sq_s),
        .out_side  (sq_side)
    );

    sav_mult u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_v),
        .in_ratio  (sq_r),
        .in_root   (sq_s),
        .in_side   (sq_side),
        .scale     (scale_reg),
        .out_valid (mul_v),
        .out_w     (mul_w),
        .out_side  (mul_side)
    );

    sav_quot u_quot (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (mul_v),
        .in_w      (mul_w),
        .in_side   (mul_side),
        .out_valid (quo_v),
        .out_q     (quo_q),
        .out_sat   (quo_sat),
        .out_side  (quo_side)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            out_v_reg <= quo_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (quo_side.zero)
            begin
                visc_reg <= '0;
                sat_reg  <= 1'b0;
            end
            else if (quo_sat)
            begin
                visc_reg <= VISC_MAX;
                sat_reg  <= 1'b1;
            end
            else
            begin
                visc_reg <= quo_q;
                sat_reg  <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {3'b000, sat_reg, visc_reg};

endmodule

// ===== tb/sv/sav_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sav_checker
// predicts and checks the viscosity results of sutherland_air_viscosity
// ----------------------------------------------------------------------------
// Follows the register writes and every accepted temperature beat. For each
// one it works out the expected viscosity and clip flag with wide integer
// arithmetic. Each output beat is then compared against the oldest one still
// waiting. The failure count and the number of open results go to the top.
// ----------------------------------------------------------------------------
module sav_checker
    import sav_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [15:0]          s_tdata,    // temp_c[14:0]
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [23:0]          m_tdata,    // viscosity[19:0], saturated[20]
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   fail_count,
    output int                   pending
);

    typedef struct packed {
        logic              saturated;
        logic [VISC_W-1:0] viscosity;
    } visc_beat_t;

    logic [VISC_W-1:0] mu0;
    logic [KT_W-1:0]   ref_temp;
    logic [KT_W-1:0]   suth_c;
    visc_beat_t        expected_visc[$];

    function automatic visc_beat_t predict_viscosity(
        input logic [TEMP_W-1:0] temp_raw,
        input logic [VISC_W-1:0] m0,
        input logic [KT_W-1:0]   t0_reg,
        input logic [KT_W-1:0]   c_reg
    );
        logic signed [KT_W:0] tk;
        logic [127:0]         t, t0, c, r, x, s, cand, p, w, q, mu;
        visc_beat_t           res;
        int                   i;
        tk = $signed(temp_raw) + KELVIN_OFFSET;
        res = '0;
        if (tk <= 0)
            return res;
        t  = 128'(tk);
        t0 = (t0_reg == '0) ? 128'd1 : 128'(t0_reg);
        c  = 128'(c_reg);
        r  = ((t << 32) + (t0 >> 1)) / t0;
        x  = r << 32;
        s  = '0;
        for (i = 63; i >= 0; i--)
        begin
            cand = s | (128'd1 << i);
            if (cand * cand <= x)
                s = cand;
        end
        if (x - s * s > s)
            s = s + 1;
        p  = (r * s + (128'd1 << 31)) >> 32;
        w  = 128'(m0) * (t0 + c) * p + (t + c) * (128'd1 << 31);
        q  = w / (t + c);
        mu = q >> 32;
        if (mu > 128'(VISC_MAX))
        begin
            res.viscosity = VISC_MAX;
            res.saturated = 1'b1;
        end
        else
            res.viscosity = mu[VISC_W-1:0];
        return res;
    endfunction

    assign pending = expected_visc.size();

    always @(posedge clk or negedge rst_n)
    begin
        visc_beat_t got, want;
        if (!rst_n)
        begin
            mu0        <= REF_VISC_RESET;
            ref_temp   <= REF_TEMP_RESET;
            suth_c     <= SUTH_CONST_RESET;
            fail_count <= 0;
            expected_visc.delete();
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_REF_VISC:   mu0      <= cfg_data[VISC_W-1:0];
                    REG_REF_TEMP:   ref_temp <= cfg_data[KT_W-1:0];
                    REG_SUTH_CONST: suth_c   <= cfg_data[KT_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_visc.push_back(
                    predict_viscosity(s_tdata[TEMP_W-1:0], mu0, ref_temp, suth_c));
            if (m_tvalid && m_tready)
            begin
                got = visc_beat_t'(m_tdata[VISC_W:0]);
                if (expected_visc.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected beat: viscosity %0d saturated %0b",
                                 got.viscosity, got.saturated);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_visc.pop_front();
                    if (got.viscosity !== want.viscosity
                        || got.saturated !== want.saturated)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: viscosity exp %0d got %0d, sat exp %0b got %0b",
                                     want.viscosity, got.viscosity,
                                     want.saturated, got.saturated);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/sv/tb_sutherland_air_viscosity.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sutherland_air_viscosity
// stream test of the sutherland viscosity pipeline
// ----------------------------------------------------------------------------
// Sends directed edge temperatures, then random ones under several register
// settings, including the extremes. Both stream sides stall at random. One
// long output hold-off backs the pipeline up into its input. The checker
// beside the block predicts every result and counts the failures.
// ----------------------------------------------------------------------------
module tb_sutherland_air_viscosity;
    import sav_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = 150;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [15:0]          s_tdata;    // temp_c[14:0]
    logic                 m_tvalid;
    logic                 m_tready;
    logic [23:0]          m_tdata;    // viscosity[19:0], saturated[20]
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int                   fail_count;
    int                   pending;
    int                   src_idle_pct;
    int                   sink_idle_pct;
    logic                 hold_req;
    int                   cycles;

    sutherland_air_viscosity dut (.*);

    sav_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL sutherland_air_viscosity");
            $finish;
        end
    end

    task automatic send_temp(input logic [TEMP_W-1:0] temp);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, temp};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic logic [TEMP_W-1:0] random_temp();
        if ($urandom_range(9) == 0)
            return TEMP_W'($urandom);
        return TEMP_W'($urandom_range(20370) - 4370);
    endfunction

    // receiver: random ready, with one long hold-off on request
    initial
    begin
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    initial
    begin
        logic [TEMP_W-1:0] directed[$];
        logic [CFG_W-1:0]  mu0_v, t0_v, c_v;
        int                set;
        int                n;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_wr_en     = 1'b0;
        cfg_index     = REG_REF_VISC;
        cfg_data      = '0;
        src_idle_pct  = 23;
        sink_idle_pct = 69;
        hold_req      = 1'b0;
        cycles        = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // absolute zero and below, the ends of the field, ordinary points
        directed = '{-15'sd4370, -15'sd4371, -15'sd4369, -15'sd16384, 15'sd0,
                     15'sd16000, 15'sd16383, 15'sd1, -15'sd1, 15'sd288,
                     15'sd320, -15'sd2000, 15'sd8000, 15'sd10922, 15'sd5461};
        foreach (directed[i])
            send_temp(directed[i]);
        drain();

        for (set = 0; set < 8; set++)
        begin
            case (set)
                0: begin mu0_v = CFG_W'(REF_VISC_RESET); t0_v = CFG_W'(REF_TEMP_RESET);
                         c_v = CFG_W'(SUTH_CONST_RESET); end
                1: begin mu0_v = 20'hFFFFF; t0_v = 20'd1; c_v = 20'd0; end
                2: begin mu0_v = 20'd0; t0_v = 20'd32767; c_v = 20'd32767; end
                3: begin mu0_v = 20'hFFFFF; t0_v = 20'd0; c_v = 20'd32767; end
                4: begin mu0_v = 20'hFFFFF; t0_v = 20'd32767; c_v = 20'd0; end
                default: begin mu0_v = CFG_W'($urandom_range(20'hFFFFF));
                               t0_v = CFG_W'($urandom_range(1, 32767));
                               c_v = CFG_W'($urandom_range(32767)); end
            endcase
            write_reg(REG_REF_VISC, mu0_v);
            write_reg(REG_REF_TEMP, t0_v);
            write_reg(REG_SUTH_CONST, c_v);
            if (set == 3)
            begin
                src_idle_pct  = 69;
                sink_idle_pct = 23;
            end
            else if (set == 6)
            begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
                hold_req      = 1'b1;
            end
            for (n = 0; n < 250; n++)
            begin
                if (n == 20)
                    hold_req = 1'b0;
                if (set == 1 && n < 10)
                    send_temp(TEMP_W'(-4370 + n));
                else
                    send_temp(random_temp());
            end
            drain();
        end

        if (fail_count == 0 && pending == 0)
            $display("PASS sutherland_air_viscosity");
        else
            $display("FAIL sutherland_air_viscosity");
        $finish;
    end

endmodule
